### src/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types, constants and the per-record pick step of the ECF subflow
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ecf_pkg;

    localparam int MAX_PATHS = 8;
    localparam int IDX_W     = $clog2(MAX_PATHS);
    localparam int CNT_W     = $clog2(MAX_PATHS + 1);
    localparam int SUMQ_W    = 32 + $clog2(MAX_PATHS);
    localparam int SUMP_W    = 16 + $clog2(MAX_PATHS);

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = ((IDX_W + 3 + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [31:0] SRTT_NONE = 32'hffff_ffff;
    localparam logic [4:0]  BETA_RST  = 5'd4;
    localparam logic [15:0] MSS_RST   = 16'd1460;

    localparam logic [CFG_INDEX_W-1:0] REG_BETA = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MSS  = 8'd1;

    localparam logic [1:0] AVAIL_USABLE = 2'd0;
    localparam logic [1:0] AVAIL_TEMP   = 2'd1;
    localparam logic [1:0] AVAIL_DOWN   = 2'd2;

    typedef struct packed {
        logic [31:0] srtt;
        logic [31:0] rttvar;
        logic [15:0] cwnd;
        logic [15:0] cwnd_idle;
        logic        backup;
        logic        sent;
        logic [1:0]  avail;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic              start;
        rec_t              fast;
        rec_t              slow;
        logic [SUMQ_W-1:0] queued_sum;
        logic [SUMP_W-1:0] packets_sum;
        logic [31:0]       meta_queued;
        logic [15:0]       meta_packets;
        logic [4:0]        beta;
        logic [15:0]       mss;
    } calc_req_t;

    typedef struct packed {
        logic done;
        logic path_valid;
        logic drop;
    } calc_rsp_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best;
        logic [31:0]      low_srtt;
        logic             f_unused;
        logic             f_una;
    } pick_t;

    localparam pick_t PICK_INIT = '{found: 1'b0, best: '0, low_srtt: SRTT_NONE,
                                    f_unused: 1'b0, f_una: 1'b0};

    // One step of the lowest-RTT search among subflows of one priority class.
    function automatic pick_t pick_step(pick_t st, rec_t r, logic [IDX_W-1:0] idx,
                                        logic want);
        pick_t o;
        logic  unused;
        o      = st;
        unused = !r.sent;
        if (r.backup == want && !(!unused && st.f_unused) && r.avail < AVAIL_DOWN) begin
            if (r.avail == AVAIL_TEMP) begin
                if (unused) o.f_una = 1'b1;
            end else begin
                if (unused && !st.f_unused) begin
                    o.low_srtt = SRTT_NONE;
                    o.found    = 1'b0;
                end
                if (unused) o.f_unused = 1'b1;
                if (r.srtt < o.low_srtt) begin
                    o.low_srtt = r.srtt;
                    o.best     = idx;
                    o.found    = 1'b1;
                end
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

### src/ecf_rec_ram.sv
// ----------------------------------------------------------------------------
// ecf_rec_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_rec_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 100
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/ecf_calc.sv
// ----------------------------------------------------------------------------
// ecf_calc
// Completion-time inequality of the fast and slow path; the main products
// run in turn on one shared multiplier; owns the switching-margin bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_calc (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ecf_pkg::calc_req_t req,
    output ecf_pkg::calc_rsp_t      rsp
);

    localparam int MINUS_W = ecf_pkg::SUMQ_W + 1;
    localparam int PSUM_W  = ecf_pkg::SUMP_W;

    typedef enum logic [3:0] {
        C_IDLE, C_PKT, C_WF, C_WS, C_LHS, C_RHS, C_SCALE, C_CMP, C_LHSS, C_RHSS, C_CMP2
    } cst_t;

    cst_t                      state_reg;
    logic                      margin_reg;
    ecf_pkg::calc_rsp_t        rsp_reg;
    ecf_pkg::rec_t             rf_reg, rs_reg;
    logic [ecf_pkg::SUMQ_W-1:0] qsum_reg;
    logic [PSUM_W-1:0]         psum_reg;
    logic [31:0]               mq_reg;
    logic [15:0]               mp_reg;
    logic [4:0]                beta_reg;
    logic [15:0]               mss_reg;
    logic [31:0]               pm_reg, wf_reg, ws_reg, sndbuf_reg, xs_reg, sd_reg, t2_reg;
    logic [32:0]               xfwf_reg;
    logic [61:0]               lhs_reg;
    logic [63:0]               rhs_reg;
    logic [66:0]               lb_reg;
    logic [69:0]               rb_reg;
    logic [60:0]               lhss_reg;
    logic [63:0]               rhss_reg;

    logic [15:0]        cwf, cws, diff;
    logic [28:0]        srtt_f, srtt_s;
    logic [30:0]        delta;
    logic [MINUS_W-1:0] minus;
    logic [31:0]        sndbuf, xf;
    logic               drop_ok;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        prod;

    always_comb begin
        cwf     = (rf_reg.cwnd > rf_reg.cwnd_idle) ? rf_reg.cwnd : rf_reg.cwnd_idle;
        cws     = (rs_reg.cwnd > rs_reg.cwnd_idle) ? rs_reg.cwnd : rs_reg.cwnd_idle;
        srtt_f  = rf_reg.srtt[31:3];
        srtt_s  = rs_reg.srtt[31:3];
        delta   = (rf_reg.rttvar[31:1] > rs_reg.rttvar[31:1]) ? rf_reg.rttvar[31:1]
                                                              : rs_reg.rttvar[31:1];
        drop_ok = rs_reg.cwnd > rs_reg.cwnd_idle;
        diff    = (PSUM_W'(mp_reg) > psum_reg) ? mp_reg - psum_reg[15:0] : 16'd0;
        minus   = MINUS_W'(qsum_reg) + MINUS_W'(pm_reg);
        sndbuf  = (MINUS_W'(mq_reg) > minus) ? mq_reg - minus[31:0] : 32'd0;
        xf      = (sndbuf_reg > wf_reg) ? sndbuf_reg : wf_reg;

        // shared multiplier operands
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            C_PKT: begin mul_a = 33'(diff);   mul_b = 32'(mss_reg); end
            C_WF:  begin mul_a = 33'(cwf);    mul_b = 32'(mss_reg); end
            C_WS:  begin mul_a = 33'(cws);    mul_b = 32'(mss_reg); end
            C_LHS: begin mul_a = xfwf_reg;    mul_b = 32'(srtt_f);  end
            C_RHS: begin mul_a = 33'(sd_reg); mul_b = wf_reg;       end
            C_LHSS: begin mul_a = 33'(xs_reg); mul_b = 32'(srtt_s); end
            C_RHSS: begin mul_a = 33'(t2_reg); mul_b = ws_reg;      end
            default: begin mul_a = '0;        mul_b = '0;           end
        endcase
        prod = 65'(mul_a) * 65'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            margin_reg <= 1'b0;
            rsp_reg    <= '0;
        end else begin
            rsp_reg.done <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (req.start) begin
                        rf_reg    <= req.fast;
                        rs_reg    <= req.slow;
                        qsum_reg  <= req.queued_sum;
                        psum_reg  <= req.packets_sum;
                        mq_reg    <= req.meta_queued;
                        mp_reg    <= req.meta_packets;
                        beta_reg  <= req.beta;
                        mss_reg   <= req.mss;
                        state_reg <= C_PKT;
                    end
                end
                C_PKT: begin
                    pm_reg    <= prod[31:0];
                    sd_reg    <= 32'(srtt_s) + 32'(delta);
                    t2_reg    <= {2'b00, srtt_f, 1'b0} + 32'(delta);
                    state_reg <= C_WF;
                end
                C_WF: begin
                    wf_reg     <= prod[31:0];
                    sndbuf_reg <= sndbuf;
                    state_reg  <= C_WS;
                end
                C_WS: begin
                    ws_reg    <= prod[31:0];
                    xfwf_reg  <= 33'(xf) + 33'(wf_reg);
                    state_reg <= C_LHS;
                end
                C_LHS: begin
                    lhs_reg   <= prod[61:0];
                    xs_reg    <= (sndbuf_reg > ws_reg) ? sndbuf_reg : ws_reg;
                    state_reg <= C_RHS;
                end
                C_RHS: begin
                    rhs_reg   <= prod[63:0];
                    state_reg <= C_SCALE;
                end
                C_SCALE: begin
                    lb_reg    <= 67'(lhs_reg) * 67'(beta_reg);
                    rb_reg    <= 70'(rhs_reg) * 70'(6'(beta_reg) + 6'(margin_reg));
                    state_reg <= C_CMP;
                end
                C_CMP: begin
                    if (70'(lb_reg) < rb_reg) begin
                        state_reg <= C_LHSS;
                    end else begin
                        margin_reg <= 1'b0;
                        rsp_reg    <= '{done: 1'b1, path_valid: 1'b1, drop: drop_ok};
                        state_reg  <= C_IDLE;
                    end
                end
                C_LHSS: begin
                    lhss_reg  <= prod[60:0];
                    state_reg <= C_RHSS;
                end
                C_RHSS: begin
                    rhss_reg  <= prod[63:0];
                    state_reg <= C_CMP2;
                end
                C_CMP2: begin
                    if (64'(lhss_reg) >= rhss_reg) begin
                        // slow path would finish later: hold the segment
                        margin_reg <= 1'b1;
                        rsp_reg    <= '{done: 1'b1, path_valid: 1'b0, drop: 1'b0};
                    end else begin
                        rsp_reg    <= '{done: 1'b1, path_valid: 1'b1, drop: drop_ok};
                    end
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

### src/ecf_subflow_scheduler.sv
// ----------------------------------------------------------------------------
// ecf_subflow_scheduler
// Earliest-completion-first subflow choice over a batch of subflow records.
// ----------------------------------------------------------------------------
// Input stream s_*: one subflow record per transfer; s_tlast marks the last
// record of a batch and starts the decision. Up to MAX_PATHS records are
// kept in a record RAM; further records of a batch are dropped.
// Output stream m_*: one result per batch (chosen path, valid, clear marks,
// drop idle window), held in an output register until taken.
// Config channel cfg_*: index 0 beta divisor, index 1 segment size; always
// ready; it is to be written between batches, which the block does not enforce.
// Records load at one per cycle. After the last record the decision scans
// the stored records (one RAM read per record), then, when the slow path
// needs the completion-time test, runs it, with a second comparison where
// the first does not settle it; the main products run one after another
// through a single multiplier. No records are taken until the result is loaded into
// the output register; while that register is not taken and a new batch has
// finished, the block holds and accepts no records.
// Reset clears the record count, the byte and packet sums, the margin bit and
// the config registers to 4 and 1460; the record RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_subflow_scheduler (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // srtt, rttvar, cwnd, cwnd_idle, queued, packets, is_backup,
    // already_sent, availability, meta_queued, meta_packets (low bit up)
    input  wire logic [ecf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tlast,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // chosen_path, path_valid, clear_sent_marks, drop_idle_cwnd (low bit up)
    output logic      [ecf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ecf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ecf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = ecf_pkg::IDX_W;
    localparam int CNT_W = ecf_pkg::CNT_W;
    localparam int QW    = ecf_pkg::SUMQ_W;
    localparam int PW    = ecf_pkg::SUMP_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PICK, S_RDF, S_RDS, S_START, S_WCALC, S_FIN
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             cnt_reg, iss_reg;
    logic [QW-1:0]                qsum_reg;
    logic [PW-1:0]                psum_reg;
    logic [31:0]                  mq_reg;
    logic [15:0]                  mp_reg;
    logic [4:0]                   beta_reg;
    logic [15:0]                  mss_reg;
    logic                         pv_reg;
    logic [IDX_W-1:0]             pidx_reg;
    ecf_pkg::pick_t               act_reg, bak_reg;
    logic [31:0]                  fmin_reg;
    logic [IDX_W-1:0]             fast_reg, slow_reg;
    logic                         av0_reg;
    ecf_pkg::rec_t                rf_reg;
    logic [IDX_W-1:0]             res_chosen_reg;
    logic                         res_valid_reg, res_clear_reg, res_drop_reg;
    logic                         m_tvalid_reg;
    logic [ecf_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    ecf_pkg::rec_t      in_rec, rd_rec;
    logic [31:0]        in_queued;
    logic [15:0]        in_packets;
    logic               acc, store;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ecf_pkg::REC_W-1:0] ram_rdata;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   nm1, slow_idx;
    logic               a_force, b_force;
    ecf_pkg::calc_req_t req;
    ecf_pkg::calc_rsp_t rsp;

    assign in_rec.srtt      = s_tdata[31:0];
    assign in_rec.rttvar    = s_tdata[63:32];
    assign in_rec.cwnd      = s_tdata[79:64];
    assign in_rec.cwnd_idle = s_tdata[95:80];
    assign in_queued        = s_tdata[127:96];
    assign in_packets       = s_tdata[143:128];
    assign in_rec.backup    = s_tdata[144];
    assign in_rec.sent      = s_tdata[145];
    assign in_rec.avail     = s_tdata[147:146];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && s_tready;
    assign store     = acc && (cnt_reg < CNT_W'(ecf_pkg::MAX_PATHS));
    assign rd_rec    = ecf_pkg::rec_t'(ram_rdata);

    // reads start only after the batch is closed, so no write can overlap them
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = iss_reg[IDX_W-1:0];
        case (state_reg)
            S_SCAN: ram_re = (iss_reg < cnt_reg);
            S_RDF:  begin ram_re = 1'b1; ram_raddr = fast_reg; end
            S_RDS:  begin ram_re = 1'b1; ram_raddr = slow_reg; end
            default: ram_re = 1'b0;
        endcase
    end

    always_comb begin
        cnt_m1   = cnt_reg - CNT_W'(1);
        nm1      = cnt_m1[IDX_W-1:0];
        slow_idx = (fast_reg == nm1) ? nm1 - IDX_W'(1) : nm1;
        a_force  = act_reg.found ? act_reg.f_unused : act_reg.f_una;
        b_force  = bak_reg.found ? bak_reg.f_unused : bak_reg.f_una;
    end

    always_comb begin
        req.start        = (state_reg == S_START);
        req.fast         = rf_reg;
        req.slow         = rd_rec;
        req.queued_sum   = qsum_reg;
        req.packets_sum  = psum_reg;
        req.meta_queued  = mq_reg;
        req.meta_packets = mp_reg;
        req.beta         = beta_reg;
        req.mss          = mss_reg;
    end

    ecf_rec_ram #(
        .DEPTH (ecf_pkg::MAX_PATHS),
        .WIDTH (ecf_pkg::REC_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (store),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (in_rec),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ecf_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            qsum_reg     <= '0;
            psum_reg     <= '0;
            beta_reg     <= ecf_pkg::BETA_RST;
            mss_reg      <= ecf_pkg::MSS_RST;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ecf_pkg::REG_BETA: beta_reg <= cfg_data[4:0];
                    ecf_pkg::REG_MSS:  mss_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (store) begin
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        qsum_reg <= qsum_reg + QW'(in_queued);
                        psum_reg <= psum_reg + PW'(in_packets);
                    end
                    if (acc && s_tlast) begin
                        mq_reg    <= s_tdata[179:148];
                        mp_reg    <= s_tdata[195:180];
                        iss_reg   <= '0;
                        pv_reg    <= 1'b0;
                        act_reg   <= ecf_pkg::PICK_INIT;
                        bak_reg   <= ecf_pkg::PICK_INIT;
                        fmin_reg  <= ecf_pkg::SRTT_NONE;
                        fast_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    pv_reg   <= ram_re;
                    pidx_reg <= iss_reg[IDX_W-1:0];
                    if (ram_re) iss_reg <= iss_reg + CNT_W'(1);
                    if (pv_reg) begin
                        act_reg <= ecf_pkg::pick_step(act_reg, rd_rec, pidx_reg, 1'b0);
                        bak_reg <= ecf_pkg::pick_step(bak_reg, rd_rec, pidx_reg, 1'b1);
                        if (rd_rec.srtt < fmin_reg) begin
                            fmin_reg <= rd_rec.srtt;
                            fast_reg <= pidx_reg;
                        end
                        if (pidx_reg == '0) av0_reg <= (rd_rec.avail == ecf_pkg::AVAIL_USABLE);
                    end
                    // last record is being folded in this cycle
                    if (iss_reg == cnt_reg) state_reg <= S_PICK;
                end
                S_PICK: begin
                    slow_reg       <= slow_idx;
                    res_clear_reg  <= 1'b0;
                    res_drop_reg   <= 1'b0;
                    res_chosen_reg <= '0;
                    res_valid_reg  <= 1'b0;
                    state_reg      <= S_FIN;
                    if (cnt_reg == CNT_W'(1)) begin
                        res_valid_reg <= av0_reg;
                    end else if (a_force && act_reg.found && act_reg.best == fast_reg) begin
                        res_chosen_reg <= act_reg.best;
                        res_valid_reg  <= 1'b1;
                    end else if (a_force && act_reg.found && act_reg.best == slow_idx) begin
                        state_reg <= S_RDF;
                    end else begin
                        res_clear_reg <= !b_force;
                        if (bak_reg.found) begin
                            res_chosen_reg <= bak_reg.best;
                            res_valid_reg  <= 1'b1;
                        end
                    end
                end
                S_RDF: state_reg <= S_RDS;
                S_RDS: begin
                    rf_reg    <= rd_rec;
                    state_reg <= S_START;
                end
                S_START: state_reg <= S_WCALC;
                S_WCALC: begin
                    if (rsp.done) begin
                        res_valid_reg  <= rsp.path_valid;
                        res_chosen_reg <= rsp.path_valid ? slow_reg : '0;
                        res_drop_reg   <= rsp.drop;
                        state_reg      <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= ecf_pkg::OUT_TDATA_W'({res_drop_reg, res_clear_reg,
                                                              res_valid_reg, res_chosen_reg});
                        cnt_reg      <= '0;
                        qsum_reg     <= '0;
                        psum_reg     <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // record count never runs past the RAM depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ecf_pkg::MAX_PATHS))
        else $error("record count above depth");

    // a wait or empty result carries path index zero
    a_wait_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[IDX_W]) |-> (m_tdata_reg[IDX_W-1:0] == '0))
        else $error("nonzero path index without a valid path");

    // idle window drop only comes with a chosen path
    a_drop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[IDX_W+2]) |-> m_tdata_reg[IDX_W])
        else $error("drop without chosen path");

    // the inequality unit only answers while it is awaited
    a_calc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == S_WCALC))
        else $error("unexpected inequality result");

    // fast and slow path of an inequality run differ
    a_fast_slow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_START) |-> (fast_reg != slow_reg))
        else $error("fast and slow path coincide");

endmodule

`default_nettype wire

### tb/ecf_subflow_scheduler_tb.sv
// ----------------------------------------------------------------------------
// ecf_subflow_scheduler_tb
// Self-checking bench for the ECF subflow scheduler. Batches of subflow
// records go in on the s_ stream; a predictor keeps its own record store,
// sums and margin bit and queues one expected decision per batch, which is
// compared field by field with each m_ transfer. Both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_subflow_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] srtt, rttvar, queued, meta_queued;
        logic [15:0] cwnd, cwnd_idle, packets, meta_packets;
        logic        backup, sent, last;
        logic [1:0]  avail;
    } subflow_rec_t;

    typedef struct packed {
        logic       drop;
        logic       clear;
        logic       valid;
        logic [2:0] chosen;
    } decision_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [ecf_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ecf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ecf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ecf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    ecf_subflow_scheduler u_top (.*);

    // predictor state
    subflow_rec_t stored[ecf_pkg::MAX_PATHS];
    int unsigned  stored_cnt;
    logic [63:0]  q_sum, p_sum;
    logic         margin;
    logic [4:0]   beta;
    logic [15:0]  mss;

    decision_t    pending_decisions[$];
    int unsigned  errors, records_sent, decisions_seen, waits_seen, slow_tests;
    bit           tx_busy_mode, rx_busy_mode;
    int unsigned  rx_stall;

    initial forever #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int pick_best(input int n, input logic want, output bit force_pick);
        int          best;
        logic [31:0] low_srtt;
        bit          f_unused, f_una, unused;
        best = -1; low_srtt = ecf_pkg::SRTT_NONE; f_unused = 0; f_una = 0;
        for (int i = 0; i < n; i++) begin
            unused = !stored[i].sent;
            if (stored[i].backup != want || (!unused && f_unused) ||
                stored[i].avail >= ecf_pkg::AVAIL_DOWN)
                continue;
            if (stored[i].avail == ecf_pkg::AVAIL_TEMP) begin
                if (unused) f_una = 1;
                continue;
            end
            if (unused) begin
                if (!f_unused) begin
                    low_srtt = ecf_pkg::SRTT_NONE;
                    best = -1;
                end
                f_unused = 1;
            end
            if (stored[i].srtt < low_srtt) begin
                low_srtt = stored[i].srtt;
                best = i;
            end
        end
        force_pick = (best >= 0) ? f_unused : f_una;
        return best;
    endfunction

    function automatic logic [63:0] max64(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic decision_t decide_batch(input logic [31:0] mq, input logic [15:0] mp);
        decision_t   d;
        int          n, fast, slow, sk;
        bit          force_pick;
        logic [31:0] min_rtt;
        logic [63:0] diff, minus, sndbuf, cwf, cws, srtt_f, srtt_s, delta, wf, ws, x_f, x_s;
        logic [63:0] lhs, rhs, lhs_s, rhs_s;
        logic [127:0] lhs_w, rhs_w;
        d = '0; n = stored_cnt; fast = 0; slow = 0; min_rtt = ecf_pkg::SRTT_NONE;
        if (n == 1) begin
            d.valid = (stored[0].avail == ecf_pkg::AVAIL_USABLE);
            return d;
        end
        sk = pick_best(n, 1'b0, force_pick);
        for (int i = 0; i < n; i++)
            if (stored[i].srtt < min_rtt) begin
                min_rtt = stored[i].srtt;
                fast = i;
            end
        for (int i = 0; i < n; i++)
            if (i != fast) slow = i;
        if (force_pick && sk >= 0 && sk == fast) begin
            d.chosen = 3'(sk); d.valid = 1'b1;
            return d;
        end
        if (force_pick && sk >= 0 && sk == slow) begin
            slow_tests++;
            diff   = (64'(mp) > p_sum) ? 64'(mp) - p_sum : 64'd0;
            minus  = q_sum + diff * 64'(mss);
            sndbuf = (64'(mq) > minus) ? 64'(mq) - minus : 64'd0;
            cwf    = max64(64'(stored[fast].cwnd), 64'(stored[fast].cwnd_idle));
            cws    = max64(64'(stored[sk].cwnd), 64'(stored[sk].cwnd_idle));
            srtt_f = 64'(stored[fast].srtt >> 3);
            srtt_s = 64'(stored[sk].srtt >> 3);
            delta  = max64(64'(stored[fast].rttvar >> 1), 64'(stored[sk].rttvar >> 1));
            wf     = cwf * 64'(mss);
            ws     = cws * 64'(mss);
            x_f    = max64(sndbuf, wf);
            lhs    = srtt_f * (x_f + wf);
            rhs    = wf * (srtt_s + delta);
            lhs_w  = {64'd0, lhs} * 128'(beta);
            rhs_w  = {64'd0, rhs} * (128'(beta) + 128'(margin));
            if (lhs_w < rhs_w) begin
                x_s   = max64(sndbuf, ws);
                lhs_s = srtt_s * x_s;
                rhs_s = ws * (64'd2 * srtt_f + delta);
                if (lhs_s >= rhs_s) begin
                    margin = 1'b1;
                    return d;
                end
            end else begin
                margin = 1'b0;
            end
            d.chosen = 3'(sk); d.valid = 1'b1;
            d.drop = stored[sk].cwnd > stored[sk].cwnd_idle;
            return d;
        end
        sk = pick_best(n, 1'b1, force_pick);
        d.clear = !force_pick;
        if (sk >= 0) begin
            d.chosen = 3'(sk); d.valid = 1'b1;
        end
        return d;
    endfunction

    function automatic void absorb_record(input subflow_rec_t r);
        if (stored_cnt < ecf_pkg::MAX_PATHS) begin
            stored[stored_cnt] = r;
            q_sum += 64'(r.queued);
            p_sum += 64'(r.packets);
            stored_cnt++;
        end
        if (r.last) begin
            pending_decisions.push_back(decide_batch(r.meta_queued, r.meta_packets));
            stored_cnt = 0; q_sum = 0; p_sum = 0;
        end
    endfunction

    // check each result transfer and pace m_tready
    always @(posedge aclk) begin
        decision_t got, want;
        int unsigned stall_next;
        stall_next = rx_stall;
        if (m_tvalid && m_tready) begin
            got = m_tdata[5:0];
            decisions_seen++;
            if (pending_decisions.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = pending_decisions.pop_front();
                if (!want.valid) waits_seen++;
                if (got.chosen != want.chosen)
                    report_mismatch("chosen_path", got.chosen, want.chosen);
                if (got.valid != want.valid)
                    report_mismatch("path_valid", got.valid, want.valid);
                if (got.clear != want.clear)
                    report_mismatch("clear_sent_marks", got.clear, want.clear);
                if (got.drop != want.drop)
                    report_mismatch("drop_idle_cwnd", got.drop, want.drop);
            end
            stall_next = rx_busy_mode ? $urandom_range(0, 6) : 0;
        end else if (stall_next > 0) begin
            stall_next--;
        end
        rx_stall = stall_next;
        if (aresetn) m_tready <= (stall_next == 0);
    end

    task automatic send_record(input subflow_rec_t r);
        int unsigned gap;
        s_tdata  <= {4'd0, r.meta_packets, r.meta_queued, r.avail, r.sent, r.backup, r.packets,
                     r.queued, r.cwnd_idle, r.cwnd, r.rttvar, r.srtt};
        s_tlast  <= r.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        absorb_record(r);
        records_sent++;
        gap = tx_busy_mode ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop the input first so a finished record is never offered again
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ecf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ecf_pkg::REG_BETA) beta = val[4:0];
        else if (idx == ecf_pkg::REG_MSS) mss = val;
    endtask

    function automatic logic [31:0] rand_srtt();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return ecf_pkg::SRTT_NONE;
            default: return $urandom_range(8, 40000);
        endcase
    endfunction

    function automatic subflow_rec_t rand_record(input bit last);
        subflow_rec_t r;
        r.srtt      = rand_srtt();
        r.rttvar    = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 20000);
        r.cwnd      = 16'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 64));
        r.cwnd_idle = 16'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 64));
        r.queued    = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200000);
        r.packets   = 16'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100));
        r.backup    = ($urandom_range(0, 4) == 0);
        r.sent      = 1'($urandom_range(0, 1));
        r.avail     = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3))
                                                  : ecf_pkg::AVAIL_USABLE;
        r.meta_queued  = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 3000000);
        r.meta_packets = 16'(($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 400));
        r.last      = last;
        return r;
    endfunction

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++) send_record(rand_record(i == n - 1));
    endtask

    // a ready-made record: usable, unsent, active
    function automatic subflow_rec_t plain(input logic [31:0] srtt, input bit last);
        subflow_rec_t r;
        r = rand_record(last);
        r.srtt = srtt; r.avail = ecf_pkg::AVAIL_USABLE; r.sent = 1'b0; r.backup = 1'b0;
        return r;
    endfunction

    task automatic test_single_path();
        subflow_rec_t r;
        for (int a = 0; a < 4; a++) begin
            r = rand_record(1'b1);
            r.avail = 2'(a);
            send_record(r);
        end
    endtask

    task automatic test_extremes();
        subflow_rec_t r;
        r = plain(32'hffff_ffff, 1'b0);
        r.rttvar = '1; r.cwnd = '1; r.cwnd_idle = '1; r.queued = '1; r.packets = '1;
        r.meta_queued = '1; r.meta_packets = '1; r.backup = 1'b1; r.sent = 1'b1;
        send_record(r);
        r = plain(32'd0, 1'b1);
        r.rttvar = '0; r.cwnd = '0; r.cwnd_idle = '0; r.queued = '0; r.packets = '0;
        r.meta_queued = '0; r.meta_packets = '0;
        send_record(r);
        // no srtt below the none marker: path 0 becomes the fast path
        send_record(plain(ecf_pkg::SRTT_NONE, 1'b0));
        send_record(plain(ecf_pkg::SRTT_NONE, 1'b1));
    endtask

    task automatic test_slow_path();
        subflow_rec_t f, s;
        // fast path already carries the segment, so the unused slow path is picked
        for (int k = 0; k < 4; k++) begin
            f = plain(32'd800, 1'b0);
            f.sent = 1'b1; f.cwnd = 16'd10; f.cwnd_idle = 16'd2; f.rttvar = 32'd100;
            s = plain((k < 2) ? 32'd8000 : 32'd900, 1'b1);
            s.cwnd = 16'd20; s.cwnd_idle = 16'd4; s.rttvar = 32'd100;
            s.meta_queued = (k % 2 != 0) ? 32'd100 : 32'd4000000; s.meta_packets = 16'd0;
            send_record(f);
            send_record(s);
        end
    endtask

    task automatic test_backup_fallback();
        subflow_rec_t r;
        r = plain(32'd500, 1'b0); r.avail = ecf_pkg::AVAIL_DOWN; send_record(r);
        r = plain(32'd700, 1'b0); r.backup = 1'b1; r.sent = 1'b1; send_record(r);
        r = plain(32'd600, 1'b1); r.backup = 1'b1; r.avail = ecf_pkg::AVAIL_TEMP;
        send_record(r);
        r = plain(32'd500, 1'b0); r.avail = ecf_pkg::AVAIL_TEMP; send_record(r);
        r = plain(32'd700, 1'b0); r.backup = 1'b1; r.sent = 1'b1; send_record(r);
        r = plain(32'd300, 1'b1); r.backup = 1'b1; r.sent = 1'b1; send_record(r);
    endtask

    task automatic test_overflow();
        send_batch(10);
        send_batch(ecf_pkg::MAX_PATHS);
    endtask

    task automatic test_register_sweep();
        logic [4:0]  betas[4] = '{5'd1, 5'd16, 5'd2, 5'd4};
        logic [15:0] sizes[4] = '{16'd1, 16'd65535, 16'd536, 16'd1460};
        for (int k = 0; k < 4; k++) begin
            write_reg(ecf_pkg::REG_BETA, 16'(betas[k]));
            write_reg(ecf_pkg::REG_MSS, sizes[k]);
            repeat (12) send_batch($urandom_range(2, 3));
        end
    endtask

    task automatic test_random_traffic();
        int n;
        while (records_sent < 850) begin
            if ($urandom_range(0, 60) == 0) begin
                write_reg(ecf_pkg::REG_BETA, 16'($urandom_range(1, 16)));
                write_reg(ecf_pkg::REG_MSS, 16'($urandom_range(1, 65535)));
            end
            if ($urandom_range(0, 20) == 0) begin
                tx_busy_mode = !tx_busy_mode;
                rx_busy_mode = 1'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 19))
                0:       n = 1;
                1:       n = $urandom_range(9, 10);
                2, 3:    n = $urandom_range(5, 8);
                default: n = $urandom_range(2, 4);
            endcase
            send_batch(n);
        end
    endtask

    initial begin
        stored_cnt = 0; q_sum = 0; p_sum = 0; margin = 1'b0;
        beta = ecf_pkg::BETA_RST; mss = ecf_pkg::MSS_RST;
        errors = 0; records_sent = 0; decisions_seen = 0; waits_seen = 0; slow_tests = 0;
        tx_busy_mode = 1; rx_busy_mode = 1; rx_stall = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_path();
        test_extremes();
        test_slow_path();
        test_backup_fallback();
        test_overflow();
        test_register_sweep();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d subflow records, checked %0d decisions (%0d waits or no path).",
                 records_sent, decisions_seen, waits_seen);
        $display("Completion-time test reached %0d times; %0d mismatches.", slow_tests, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/ecf_pkg.sv
src/ecf_rec_ram.sv
src/ecf_calc.sv
src/ecf_subflow_scheduler.sv
tb/ecf_subflow_scheduler_tb.sv
